// File: rtl/bgd_pkg.sv
`default_nettype none

package bgd_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PIX_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAYER_PATTERN = 1'd1;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST = 13'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_MIN = 13'd2;

endpackage

`default_nettype wire

// File: rtl/bayer_green_downsample.sv
// Bayer green 2x2 downsampler.
// Input channel (in_valid_i/in_ready_o): raw samples in raster order, one byte
// per word; frame_start_i marks the first pixel of a frame and clears the
// row/column counters. Output channel (out_valid_o/out_ready_i): one word per
// 2x2 block, the floor of the mean of its two greens; row_end_o flags the
// last word of an output row. Odd trailing columns and rows give no output.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 image width,
// 1 pattern); write only while idle.
// Throughput: one input word per cycle while in_ready_o is high. The top-row
// green is parked in a half-width line RAM (one synchronous read port, one
// write port); its read on the bottom row is registered in the read stage
// with that green; their mean then fills the output register (green_mean_o).
// Stall: a read stage and an output register sit between the channels, so
// input keeps flowing while a result waits; in_ready_o drops only when both
// are full and out_ready_i is low.
// Reset: counters and valid flags clear, width reads 640, pattern 0; the line
// RAM is not cleared (every entry is written by a top row before it is read).
`default_nettype none

module bayer_green_downsample
  import bgd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIX_W-1:0]      pixel_value_i,
  input  wire logic                  frame_start_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [PIX_W-1:0]           green_mean_o,
  output logic                       row_end_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned HD = MAX_WIDTH / 2;
  localparam int unsigned AW = (HD > 1) ? $clog2(HD) : 1;
  localparam int unsigned MW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW = (MW > CFG_DATA_W) ? MW : CFG_DATA_W;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

  logic [CFG_DATA_W-1:0] width_q;
  logic                  pat_q;
  logic [CW-1:0]         col_q, col_d;
  logic                  odd_q, odd_d;

  logic [PIX_W-1:0] ram_q [HD];
  logic [PIX_W-1:0] rd_q;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_last_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_data_q;
  logic             out_last_q;

  logic [WW-1:0]   wext, act_w, blocks, col_ext, blk_ext, col_inc;
  logic [CW-1:0]   col_eff;
  logic            odd_eff, gphase, hit, accept, s1_adv;
  logic [CW-2:0]   blk;
  logic [AW-1:0]   addr;
  logic [PIX_W:0]  sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= IMAGE_WIDTH_RST;
      pat_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   width_q <= cfg_wdata_i;
        CFG_BAYER_PATTERN: pat_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wext = WW'(width_q);
    if (wext < WW'(IMAGE_WIDTH_MIN)) begin
      act_w = WW'(IMAGE_WIDTH_MIN);
    end else if (wext > MAXW) begin
      act_w = MAXW;
    end else begin
      act_w = wext;
    end
    blocks  = act_w >> 1;
    col_eff = frame_start_i ? '0 : col_q;
    odd_eff = frame_start_i ? 1'b0 : odd_q;
    blk     = col_eff[CW-1:1];
    addr    = AW'(blk);
    col_ext = WW'(col_eff);
    blk_ext = WW'(blk);
    col_inc = col_ext + WW'(1);
    gphase  = odd_eff ^ ~pat_q;
    hit     = (col_ext < act_w) && (blk_ext < blocks) && (col_eff[0] == gphase);
    if (col_inc >= act_w) begin
      col_d = '0;
      odd_d = ~odd_eff;
    end else begin
      col_d = col_inc[CW-1:0];
      odd_d = odd_eff;
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      odd_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      odd_q <= odd_d;
    end
  end

  // line RAM: top-row write, bottom-row read; same entry never hit in one cycle
  always_ff @(posedge clk_i) begin
    if (accept && hit && !odd_eff) begin
      ram_q[addr] <= pixel_value_i;
    end
    if (accept && hit && odd_eff) begin
      rd_q <= ram_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && hit && odd_eff) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sum = {1'b0, rd_q} + {1'b0, s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (accept && hit && odd_eff) begin
      s1_pix_q  <= pixel_value_i;
      s1_last_q <= (blk_ext + WW'(1)) == blocks;
    end
    if (s1_adv) begin
      out_data_q <= sum[PIX_W:1];
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign green_mean_o = out_data_q;
  assign row_end_o    = out_last_q;

`ifndef ASSERT_OFF
  a_ready_low_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with free pipeline slot");

  a_s1_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && hit && odd_eff) |=> s1_valid_q)
    else $error("bottom-row green lost before read stage");

  a_s1_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("read stage advanced without output word");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q && $stable(s1_pix_q))
    else $error("stalled read stage changed");
`endif

endmodule

`default_nettype wire
